@@ hw/rtl/f2da_pkg.sv @@
// shared types, constants and helpers for the float to decimal text block
package f2da_pkg;

  // parameter defaults
  localparam int MAX_FRAC_DIGITS_DEF = 9;
  localparam int MAX_INT_DIGITS_DEF  = 10;

  // configuration register reset value
  localparam logic [3:0] FRAC_DIGITS_RST = 4'd9;

  // character codes
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;
  localparam logic [7:0] ASCII_NUL  = 8'h00;
  localparam logic [7:0] DIGIT_MAX  = 8'd9;

  // datapath widths
  localparam int CONV_BITS  = 32;
  localparam int STEP_BITS  = 4;
  localparam int CONV_STEPS = CONV_BITS / STEP_BITS;
  localparam int IPART_W    = 31;
  localparam int FNUM_W     = 24;
  localparam int POW_W      = 30;
  localparam int PROD_W     = FNUM_W + POW_W;
  localparam int FVAL_W     = 30;

  // biased exponent landmarks
  localparam logic [7:0] EXP_ONE     = 8'd127;  // value in [1,2)
  localparam logic [7:0] EXP_INT     = 8'd150;  // lsb of significand weighs 1
  localparam logic [7:0] EXP_TOO_BIG = 8'd158;  // 2^31 and above
  localparam logic [7:0] SUBN_SHIFT  = 8'd149;  // fraction bits of a subnormal
  localparam logic [7:0] SHIFT_ZERO  = 8'd54;   // product shifted this far is zero

  typedef struct packed {
    logic load;
    logic decode;
    logic mult;
    logic shift;
    logic conv;
    logic len;
    logic emit;
  } f2da_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic out_free;
    logic char_last;
  } f2da_sts_t;

  function automatic logic [33:0] pow10(input logic [3:0] n);
    logic [33:0] p;
    case (n)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      4'd10:   p = 34'd10000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/f2da_in_if.sv @@
// input channel: one single-precision bit pattern per transaction
interface f2da_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

@@ hw/rtl/f2da_out_if.sv @@
// output channel: one text character per transaction
interface f2da_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_last;
  logic       bad_input;

  modport source (output valid, output out_char, output is_last, output bad_input,
                  input ready);
  modport sink   (input valid, input out_char, input is_last, input bad_input,
                  output ready);
endinterface

@@ hw/rtl/f2da_ctrl.sv @@
// sequencer for decode, scaling, bcd conversion and character output
module f2da_ctrl import f2da_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  f2da_sts_t sts,
  output f2da_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_MULT  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CONV  = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_CONV;
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_last) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.char_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("character issued while output register is occupied");
`endif

endmodule

@@ hw/rtl/f2da_dp.sv @@
// datapath: decode, fraction scaling, binary to bcd and character selection
module f2da_dp import f2da_pkg::*; #(
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  parameter int MAX_INT_DIGITS  = MAX_INT_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic [31:0] in_value,
  input  f2da_cmd_t   cmd,
  output f2da_sts_t   sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic        out_bad
);

  localparam int IBCD_W = 4 * MAX_INT_DIGITS;
  localparam int FBCD_W = 4 * MAX_FRAC_DIGITS;
  localparam int ICW    = $clog2(MAX_INT_DIGITS + 1);
  localparam int FCW    = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int IIX    = (MAX_INT_DIGITS > 1) ? $clog2(MAX_INT_DIGITS) : 1;
  localparam int FIX    = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
  localparam logic [33:0] INT_LIMIT = pow10(4'(MAX_INT_DIGITS));
  localparam logic [3:0]  K_MAX     = 4'(MAX_FRAC_DIGITS);

  logic [3:0]           frac_digits;
  logic [31:0]          value;
  logic [3:0]           k;
  logic                 err;
  logic [IPART_W-1:0]   ipart;
  logic [FNUM_W-1:0]    fnum;
  logic [7:0]           s;
  logic [PROD_W-1:0]    prod;
  logic [CONV_BITS-1:0] isrc, fsrc;
  logic [IBCD_W-1:0]    bcd_i;
  logic [FBCD_W-1:0]    bcd_f;
  logic [2:0]           conv_cnt;
  logic [ICW-1:0]       int_cnt;
  logic [FCW-1:0]       frac_cnt;
  logic                 dot_pend;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits <= FRAC_DIGITS_RST;
    end else if (cfg_we) begin
      frac_digits <= cfg_wdata;
    end
  end

  // decode of the captured bit pattern
  logic                 sign_d;
  logic [7:0]           bexp_d;
  logic [FNUM_W-1:0]    mant_d;
  logic                 err_d;
  logic [IPART_W-1:0]   ipart_d;
  logic [FNUM_W-1:0]    fnum_d;
  logic [7:0]           s_d;
  logic [2:0]           shl_d;

  always_comb begin
    sign_d  = value[31];
    bexp_d  = value[30:23];
    mant_d  = {(bexp_d != 8'd0), value[22:0]};
    err_d   = (sign_d && (value[30:0] != 31'd0)) || (bexp_d >= EXP_TOO_BIG);
    shl_d   = 3'((bexp_d - EXP_INT) & 8'h07);
    ipart_d = '0;
    fnum_d  = '0;
    s_d     = '0;
    if (bexp_d >= EXP_INT) begin
      ipart_d = {7'd0, mant_d} << shl_d;
    end else if (bexp_d >= EXP_ONE) begin
      s_d     = EXP_INT - bexp_d;
      ipart_d = {7'd0, mant_d} >> s_d;
      fnum_d  = mant_d & ((24'd1 << s_d) - 24'd1);
    end else begin
      s_d    = (bexp_d == 8'd0) ? SUBN_SHIFT : (EXP_INT - bexp_d);
      fnum_d = mant_d;
    end
  end

  // fraction scaling
  logic [33:0]       pow_full;
  logic [POW_W-1:0]  pow_k;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] fval_full;

  assign pow_full  = pow10(k);
  assign pow_k     = pow_full[POW_W-1:0];
  assign prod_d    = fnum * pow_k;
  assign fval_full = (s >= SHIFT_ZERO) ? '0 : (prod >> s);

  // radix-16 double dabble, four bits per cycle for both parts
  logic [IBCD_W-1:0] bcd_i_d;
  logic [FBCD_W-1:0] bcd_f_d;

  always_comb begin
    bcd_i_d = bcd_i;
    bcd_f_d = bcd_f;
    for (int b = 0; b < STEP_BITS; b++) begin
      for (int d = 0; d < MAX_INT_DIGITS; d++) begin
        if (bcd_i_d[4*d +: 4] >= 4'd5) begin
          bcd_i_d[4*d +: 4] = bcd_i_d[4*d +: 4] + 4'd3;
        end
      end
      bcd_i_d = {bcd_i_d[IBCD_W-2:0], isrc[CONV_BITS-1-b]};
      for (int d = 0; d < MAX_FRAC_DIGITS; d++) begin
        if (bcd_f_d[4*d +: 4] >= 4'd5) begin
          bcd_f_d[4*d +: 4] = bcd_f_d[4*d +: 4] + 4'd3;
        end
      end
      bcd_f_d = {bcd_f_d[FBCD_W-2:0], fsrc[CONV_BITS-1-b]};
    end
  end

  // integer digit count, at least one
  logic [ICW-1:0] ndig;

  always_comb begin
    ndig = ICW'(1);
    for (int d = 0; d < MAX_INT_DIGITS; d++) begin
      if (bcd_i[4*d +: 4] != 4'd0) begin
        ndig = ICW'(d + 1);
      end
    end
  end

  // current character
  logic [IIX-1:0] i_idx;
  logic [FIX-1:0] f_idx;
  logic [7:0]     cur_char;
  logic           cur_last;

  assign i_idx = IIX'(int_cnt - ICW'(1));
  assign f_idx = FIX'(frac_cnt - FCW'(1));

  always_comb begin
    if (err) begin
      cur_char = ASCII_NUL;
      cur_last = 1'b1;
    end else if (int_cnt != '0) begin
      cur_char = ASCII_ZERO + {4'd0, bcd_i[i_idx*4 +: 4]};
      cur_last = (int_cnt == ICW'(1)) && !dot_pend;
    end else if (dot_pend) begin
      cur_char = ASCII_DOT;
      cur_last = 1'b0;
    end else begin
      cur_char = ASCII_ZERO + {4'd0, bcd_f[f_idx*4 +: 4]};
      cur_last = (frac_cnt == FCW'(1));
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= in_value;
      k     <= (frac_digits > K_MAX) ? K_MAX : frac_digits;
    end
    if (cmd.decode) begin
      err   <= err_d;
      ipart <= ipart_d;
      fnum  <= fnum_d;
      s     <= s_d;
    end
    if (cmd.mult) begin
      prod <= prod_d;
      err  <= err || ({3'd0, ipart} >= INT_LIMIT);
    end
    if (cmd.shift) begin
      isrc     <= {1'b0, ipart};
      fsrc     <= {2'd0, fval_full[FVAL_W-1:0]};
      bcd_i    <= '0;
      bcd_f    <= '0;
      conv_cnt <= '0;
    end
    if (cmd.conv) begin
      bcd_i    <= bcd_i_d;
      bcd_f    <= bcd_f_d;
      isrc     <= isrc << STEP_BITS;
      fsrc     <= fsrc << STEP_BITS;
      conv_cnt <= conv_cnt + 3'd1;
    end
    if (cmd.len) begin
      int_cnt  <= ndig;
      frac_cnt <= FCW'(k);
      dot_pend <= (k != 4'd0);
    end
    if (cmd.emit && !err) begin
      if (int_cnt != '0) begin
        int_cnt <= int_cnt - ICW'(1);
      end else if (dot_pend) begin
        dot_pend <= 1'b0;
      end else begin
        frac_cnt <= frac_cnt - FCW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= cur_char;
      out_last <= cur_last;
      out_bad  <= err;
    end
  end

  assign sts.conv_last = (conv_cnt == 3'(CONV_STEPS - 1));
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.char_last = cur_last;

`ifndef SYNTHESIS
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> out_last)
    else $error("error transaction not marked last");

  a_error_char_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> (out_char == ASCII_NUL))
    else $error("error transaction carries a character");

  a_text_charset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_bad) |-> ((out_char == ASCII_DOT) ||
      ((out_char >= ASCII_ZERO) && (out_char <= ASCII_ZERO + DIGIT_MAX))))
    else $error("text transaction is neither digit nor dot");
`endif

endmodule

@@ hw/rtl/float_to_decimal_ascii.sv @@
// float to decimal text: an accepted value is decoded, scaled, converted to
// bcd and measured, then goes out one character per cycle while the receiver
// takes them; an item has 1 to 20 characters and holds the input until its
// last one enters the output register; the pace is set by the 8-step bcd
// conversion and the single output register; synchronous active-high rst
// clears the sequencer and output valid and sets frac_digits to 9
module float_to_decimal_ascii import f2da_pkg::*; #(
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
  parameter int MAX_INT_DIGITS  = MAX_INT_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  f2da_in_if.sink    in_item,
  f2da_out_if.source out_item,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  // command and status between sequencer and datapath
  f2da_cmd_t cmd;
  f2da_sts_t sts;

  // sequencer: accepts one value, steps the datapath, paces characters
  f2da_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: exact fixed-point fraction, bcd digits, output register
  f2da_dp #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
    .MAX_INT_DIGITS  (MAX_INT_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (in_item.value_bits),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_char  (out_item.out_char),
    .out_last  (out_item.is_last),
    .out_bad   (out_item.bad_input)
  );

endmodule

@@ test/float_to_decimal_ascii_tb.sv @@
// testbench for float_to_decimal_ascii: checks the decimal text of each value
module float_to_decimal_ascii_tb;
  import f2da_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // no transaction on either channel for this many cycles means a hang
  localparam int QUIET_LIMIT = 2000;
  // cycles the receiver refuses output once, so the block backs up into its input
  localparam int HOLD_CYCLES = 400;
  // that hold starts once this many characters have gone through
  localparam int HOLD_AFTER = 60;
  // settle time after the last character, covers the front end
  localparam int DRAIN_CYCLES = 24;
  // random values sent under each fraction setting
  localparam int VALUES_PER_PHASE = 41;
  // integer parts at or above 10^10 cannot be printed
  localparam longint unsigned INT_CEIL = 64'd10_000_000_000;

  // one expected output character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } text_char_t;

  // expected text of every value taken in, oldest first
  class char_ledger;
    text_char_t due_chars[$];
    logic [3:0] frac_reg;
    int         errors;

    function new();
      frac_reg = FRAC_DIGITS_RST;
      errors   = 0;
    endfunction

    function void set_frac(logic [3:0] v);
      frac_reg = v;
    endfunction

    function int pending();
      return due_chars.size();
    endfunction

    // works out the characters for one accepted value
    function void take_value(logic [31:0] bits);
      logic [7:0]        bexp;
      logic [23:0]       mant;
      int                e;
      int                s;
      int                k;
      bit                reject;
      longint unsigned   ipart;
      longint unsigned   fnum;
      longint unsigned   fval;
      longint unsigned   scale;
      logic [7:0]        text[$];
      logic [7:0]        digits[$];

      bexp   = bits[30:23];
      reject = (bexp == 8'hFF) || (bits[31] && bits[30:0] != 31'd0);
      mant   = (bexp == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
      e      = (bexp == 8'd0) ? -126 : int'(bexp) - 127;
      if (e >= 31) reject = 1'b1;
      ipart = 0;
      fnum  = 0;
      s     = 0;
      if (!reject) begin
        if (e >= 23) begin
          ipart = longint'(mant) << (e - 23);
        end else begin
          s     = 23 - e;
          ipart = (s >= 24) ? 64'd0 : longint'(mant >> s);
          fnum  = (s >= 24) ? longint'(mant) : longint'(mant) & ((64'd1 << s) - 64'd1);
        end
        if (ipart >= INT_CEIL) reject = 1'b1;
      end
      if (reject) begin
        due_chars.push_back('{ch: ASCII_NUL, last: 1'b1, bad: 1'b1});
        return;
      end

      k     = (frac_reg > MAX_FRAC_DIGITS_DEF) ? MAX_FRAC_DIGITS_DEF : int'(frac_reg);
      scale = 1;
      repeat (k) scale = scale * 10;
      // exact: fnum < 2^24 and scale < 2^30
      fval = (s < 64) ? ((fnum * scale) >> s) : 64'd0;

      // integer part, at least one digit
      do begin
        digits.push_front(ASCII_ZERO + 8'(ipart % 10));
        ipart = ipart / 10;
      end while (ipart != 0);
      text = digits;
      if (k != 0) begin
        text.push_back(ASCII_DOT);
        digits.delete();
        repeat (k) begin
          digits.push_front(ASCII_ZERO + 8'(fval % 10));
          fval = fval / 10;
        end
        text = {text, digits};
      end
      foreach (text[i])
        due_chars.push_back('{ch: text[i], last: (i == text.size() - 1), bad: 1'b0});
    endfunction

    // compares one delivered character with the oldest expectation
    function void match_char(logic [7:0] ch, logic last, logic bad);
      text_char_t want;
      if (due_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character %h last %b bad %b", $time, ch, last, bad);
        return;
      end
      want = due_chars.pop_front();
      if (want.ch !== ch) begin
        errors++;
        $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: is_last expected %b actual %b", $time, want.last, last);
      end
      if (want.bad !== bad) begin
        errors++;
        $display("%0t: bad_input expected %b actual %b", $time, want.bad, bad);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  bit         steady;        // no idling on either side while set
  int         chars_seen = 0;
  int         quiet_cycles = 0;
  char_ledger ledger;

  f2da_in_if  in_ch();
  f2da_out_if out_ch();

  float_to_decimal_ascii uut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offers one value and returns at the edge of its input transaction;
  // valid stays up so back-to-back values need no drop in between
  task automatic send_value(input logic [31:0] v);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_bits <= v;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    ledger.take_value(v);
  endtask

  // drops valid and waits until every expected character has come out,
  // then lets the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed positive values across the printable range, plus
  // some raw patterns, negatives and oversized values
  function automatic logic [31:0] random_value();
    int         pick;
    int         zone;
    logic [7:0] bexp;
    logic [22:0] mfield;
    pick   = $urandom_range(99);
    mfield = 23'($urandom());
    if (pick < 12) return $urandom();
    if (pick < 16) return 32'h8000_0000;
    if (pick < 20) return {1'b1, 31'($urandom())};
    zone = $urandom_range(99);
    if (zone < 5)       bexp = 8'd0;
    else if (zone < 30) bexp = 8'($urandom_range(100, 126));
    else if (zone < 35) bexp = 8'($urandom_range(1, 99));
    else if (zone < 95) bexp = 8'($urandom_range(int'(EXP_ONE), int'(EXP_TOO_BIG) - 1));
    else                bexp = 8'($urandom_range(int'(EXP_TOO_BIG), 254));
    // short significands give exact fractions and trailing zeros
    if ($urandom_range(3) == 0) mfield[12:0] = 13'd0;
    return {1'b0, bexp, mfield};
  endfunction

  // output side: random stalls, one long hold-off, none while steady
  initial begin
    int  hold_left;
    bit  held;
    hold_left    = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!held && chars_seen >= HOLD_AFTER) begin
        // long refusal while the sender keeps offering values
        held         = 1'b1;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  // checks every output transaction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      ledger.match_char(out_ch.out_char, out_ch.is_last, out_ch.bad_input);
      chars_seen <= chars_seen + 1;
    end
  end

  // watchdog: counts cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("float_to_decimal_ascii_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner_values[$];
    logic [3:0]  frac_plan[6];

    ledger           = new();
    steady           = 1'b0;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = 32'd0;
    cfg_we           = 1'b0;
    cfg_wdata        = 4'd0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, under the reset setting of nine fraction digits
    corner_values = '{
      32'h0000_0000,  // zero prints a lone 0 before the dot
      32'h8000_0000,  // negative zero is plain zero
      32'h3F80_0000,  // 1.0
      32'h3F00_0000,  // 0.5
      32'h3DCC_CCCD,  // 0.1, fraction truncated
      32'h42F6_E979,  // 123.456
      32'h3F7F_FFFF,  // just below one
      32'h3FFF_FFFF,  // just below two
      32'h411F_FFFF,  // just below ten
      32'h0000_0001,  // smallest subnormal, fraction far below one digit
      32'h007F_FFFF,  // largest subnormal
      32'h0080_0000,  // smallest normal
      32'h4B00_0000,  // 2^23, last bit weighs one
      32'h4B80_0000,  // 2^24, integer shifted left
      32'h4EFF_FFFF,  // largest value below 2^31, ten integer digits
      32'h4F00_0000,  // 2^31 is too large
      32'h7F7F_FFFF,  // largest finite, too large
      32'h7F80_0000,  // positive infinity
      32'hFF80_0000,  // negative infinity
      32'h7FC0_0000,  // quiet nan
      32'h7F80_0001,  // signaling nan
      32'hFFFF_FFFF,  // nan with the sign set
      32'hBF80_0000,  // -1.0
      32'h8000_0001,  // negative smallest subnormal
      32'h4E6E_6B28   // about 10^9
    };
    foreach (corner_values[i]) send_value(corner_values[i]);

    // random part over several fraction settings: no fraction, saturation
    // above nine, one digit, nine digits with no idling, and two others
    frac_plan = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd5, 4'($urandom_range(2, 14))};
    foreach (frac_plan[p]) begin
      wait_drained();
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= frac_plan[p];
      @(negedge clk);
      cfg_we <= 1'b0;
      ledger.set_frac(frac_plan[p]);
      steady = (p == 3);
      repeat (VALUES_PER_PHASE) send_value(random_value());
    end
    steady = 1'b0;

    wait_drained();
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("float_to_decimal_ascii_tb: done, clean");
    end else begin
      $display("float_to_decimal_ascii_tb: done, errors");
    end
    $finish;
  end

endmodule
